[rtl/bdpe_pkg.sv]
// Shared types and constants for the button debouncer with press events.
`default_nettype none

package bdpe_pkg;

  localparam int IndexW = 2;
  localparam int MaxButtons = 2 ** IndexW;
  localparam int MaskW = 4;
  localparam int TimeW = 32;
  localparam int MsW = 16;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 5;
  localparam int RegIdxW = 3;

  localparam logic [1:0] EVENT_NONE        = 2'd0;
  localparam logic [1:0] EVENT_SHORT_PRESS = 2'd1;
  localparam logic [1:0] EVENT_LONG_PRESS  = 2'd2;
  localparam logic [1:0] EVENT_AUTO_REPEAT = 2'd3;

  localparam logic [RegIdxW-1:0] REG_DEBOUNCE      = 3'd0;
  localparam logic [RegIdxW-1:0] REG_LONG_PRESS    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_REPEAT_FIRST  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_REPEAT_PERIOD = 3'd3;
  localparam logic [RegIdxW-1:0] REG_RELEASE_MODE  = 3'd4;

  localparam logic [MsW-1:0] DEBOUNCE_RESET      = 16'd20;
  localparam logic [MsW-1:0] LONG_PRESS_RESET    = 16'd700;
  localparam logic [MsW-1:0] REPEAT_FIRST_RESET  = 16'd400;
  localparam logic [MsW-1:0] REPEAT_PERIOD_RESET = 16'd120;
  localparam logic [MaskW-1:0] RELEASE_MODE_RESET = 4'd3;

  typedef struct packed {
    logic [MsW-1:0]   debounce_ms;
    logic [MsW-1:0]   long_press_ms;
    logic [MsW-1:0]   repeat_first_ms;
    logic [MsW-1:0]   repeat_period_ms;
    logic [MaskW-1:0] release_mode_mask;
  } cfg_t;

  typedef struct packed {
    logic             held;
    logic             last_level;
    logic             long_reported;
    logic             tap_seen;
    logic [TimeW-1:0] change_time;
    logic [TimeW-1:0] press_time;
    logic [TimeW-1:0] repeat_time;
  } entry_t;

endpackage

`default_nettype wire

[rtl/bdpe_if.sv]
// Valid/ready channel interfaces for button samples and press event results.
`default_nettype none

interface bdpe_sample_if;
  logic        valid;
  logic        ready;
  logic [1:0]  button_index;
  logic        raw_pressed;
  logic [31:0] now_ms;

  modport source(output valid, button_index, raw_pressed, now_ms, input ready);
  modport sink(input valid, button_index, raw_pressed, now_ms, output ready);
endinterface

interface bdpe_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       ack_pulse;
  logic [3:0] stable_mask;
  logic [3:0] latched_mask;

  modport source(output valid, event_res, ack_pulse, stable_mask, latched_mask, input ready);
  modport sink(input valid, event_res, ack_pulse, stable_mask, latched_mask, output ready);
endinterface

`default_nettype wire

[rtl/bdpe_regs.sv]
// APB configuration registers for debounce, hold and repeat timing and button modes.
`default_nettype none

module bdpe_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bdpe_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bdpe_pkg::ApbDataW-1:0]  pwdata,
  output logic [bdpe_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output bdpe_pkg::cfg_t                 cfg
);

  logic                          wr_en;
  logic [bdpe_pkg::RegIdxW-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bdpe_pkg::ApbAddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms       <= bdpe_pkg::DEBOUNCE_RESET;
      cfg.long_press_ms     <= bdpe_pkg::LONG_PRESS_RESET;
      cfg.repeat_first_ms   <= bdpe_pkg::REPEAT_FIRST_RESET;
      cfg.repeat_period_ms  <= bdpe_pkg::REPEAT_PERIOD_RESET;
      cfg.release_mode_mask <= bdpe_pkg::RELEASE_MODE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        bdpe_pkg::REG_DEBOUNCE:      cfg.debounce_ms       <= pwdata[bdpe_pkg::MsW-1:0];
        bdpe_pkg::REG_LONG_PRESS:    cfg.long_press_ms     <= pwdata[bdpe_pkg::MsW-1:0];
        bdpe_pkg::REG_REPEAT_FIRST:  cfg.repeat_first_ms   <= pwdata[bdpe_pkg::MsW-1:0];
        bdpe_pkg::REG_REPEAT_PERIOD: cfg.repeat_period_ms  <= pwdata[bdpe_pkg::MsW-1:0];
        bdpe_pkg::REG_RELEASE_MODE:  cfg.release_mode_mask <= pwdata[bdpe_pkg::MaskW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bdpe_pkg::REG_DEBOUNCE:      prdata = 32'(cfg.debounce_ms);
      bdpe_pkg::REG_LONG_PRESS:    prdata = 32'(cfg.long_press_ms);
      bdpe_pkg::REG_REPEAT_FIRST:  prdata = 32'(cfg.repeat_first_ms);
      bdpe_pkg::REG_REPEAT_PERIOD: prdata = 32'(cfg.repeat_period_ms);
      bdpe_pkg::REG_RELEASE_MODE:  prdata = 32'(cfg.release_mode_mask);
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/button_debounce_press_events.sv]
// Top level of the button debouncer with short, long and repeat press events.
// A result is valid once its sample item has passed the s1 stage and output register.
// Throughput: one sample item per cycle unless the result is stalled; the per-button
// state memory is read on accept and written from s1, forwarding for repeated buttons.
// Reset clears all button state, both masks and the pipeline, and loads the register
// defaults; no clearing pass is needed, so items are accepted straight after reset.
`default_nettype none

module button_debounce_press_events #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  bdpe_sample_if.sink                   sample,
  bdpe_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdpe_pkg::ApbAddrW-1:0] paddr,
  input  logic [bdpe_pkg::ApbDataW-1:0] pwdata,
  output logic [bdpe_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  localparam int MemDepth = (NUM_BUTTONS < bdpe_pkg::MaxButtons) ? NUM_BUTTONS
                                                                 : bdpe_pkg::MaxButtons;
  localparam int AddrW = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  bdpe_pkg::cfg_t   cfg;
  bdpe_pkg::entry_t mem [MemDepth];
  bdpe_pkg::entry_t mem_rdata;
  bdpe_pkg::entry_t fwd_data;
  bdpe_pkg::entry_t cur;
  bdpe_pkg::entry_t nxt;

  logic                        advance;
  logic                        accept;
  logic                        in_range;
  logic [AddrW-1:0]            in_addr;
  logic [MemDepth-1:0]         entry_valid;
  logic                        rd_valid;
  logic                        fwd_hit;
  logic                        mem_we;
  logic                        same_addr;

  logic                        s1_valid;
  logic                        s1_in_range;
  logic [bdpe_pkg::IndexW-1:0] s1_index;
  logic [AddrW-1:0]            s1_addr;
  logic                        s1_raw;
  logic [bdpe_pkg::TimeW-1:0]  s1_now;

  logic [bdpe_pkg::MaskW-1:0]  stable_bits;
  logic [bdpe_pkg::MaskW-1:0]  latched_bits;
  logic [bdpe_pkg::MaskW-1:0]  stable_next;
  logic [bdpe_pkg::MaskW-1:0]  latched_next;
  logic [bdpe_pkg::MaskW-1:0]  bit_sel;
  logic [1:0]                  ev;
  logic                        ack;
  logic                        rel;
  logic                        settling;
  logic                        long_due;
  logic                        repeat_due;
  logic [bdpe_pkg::TimeW-1:0]  diff_change;
  logic [bdpe_pkg::TimeW-1:0]  diff_press;
  logic [bdpe_pkg::TimeW-1:0]  diff_repeat;

  logic                        out_valid;
  logic [1:0]                  out_event;
  logic                        out_ack;
  logic [bdpe_pkg::MaskW-1:0]  out_stable;
  logic [bdpe_pkg::MaskW-1:0]  out_latched;

  bdpe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance      = !out_valid || result.ready;
  assign sample.ready = advance;
  assign accept       = sample.valid && advance;
  assign in_range     = 32'(sample.button_index) < NUM_BUTTONS;
  assign in_addr      = sample.button_index[AddrW-1:0];
  assign s1_addr      = s1_index[AddrW-1:0];
  assign mem_we       = advance && s1_valid && s1_in_range;
  assign same_addr    = mem_we && (s1_addr == in_addr);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s1_addr] <= nxt;
    end
    if (accept) begin
      mem_rdata <= mem[in_addr];
      fwd_data  <= nxt;
      s1_index  <= sample.button_index;
      s1_raw    <= sample.raw_pressed;
      s1_now    <= sample.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      rd_valid     <= 1'b0;
      fwd_hit      <= 1'b0;
      s1_valid     <= 1'b0;
      s1_in_range  <= 1'b0;
      stable_bits  <= '0;
      latched_bits <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (mem_we) begin
        entry_valid[s1_addr] <= 1'b1;
      end
      if (accept) begin
        rd_valid    <= (in_range && entry_valid[in_addr]) || same_addr;
        fwd_hit     <= same_addr;
        s1_in_range <= in_range;
      end
      if (advance) begin
        s1_valid  <= accept;
        out_valid <= s1_valid;
        if (s1_valid) begin
          stable_bits  <= stable_next;
          latched_bits <= latched_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_event   <= ev;
      out_ack     <= ack;
      out_stable  <= stable_next;
      out_latched <= latched_next;
    end
  end

  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (rd_valid) begin
      cur = mem_rdata;
    end else begin
      cur = '0;
    end
  end

  assign rel         = cfg.release_mode_mask[s1_index];
  assign bit_sel     = bdpe_pkg::MaskW'(1) << s1_index;
  assign diff_change = s1_now - cur.change_time;
  assign diff_press  = s1_now - cur.press_time;
  assign diff_repeat = s1_now - cur.repeat_time;
  assign settling    = diff_change < 32'(cfg.debounce_ms);
  assign long_due    = diff_press >= 32'(cfg.long_press_ms);
  assign repeat_due  = (diff_press >= 32'(cfg.repeat_first_ms)) &&
                       (diff_repeat >= 32'(cfg.repeat_period_ms));

  always_comb begin
    nxt          = cur;
    ev           = bdpe_pkg::EVENT_NONE;
    ack          = 1'b0;
    stable_next  = stable_bits;
    latched_next = latched_bits;
    if (s1_in_range) begin
      if (s1_raw && !cur.held) begin
        nxt.tap_seen = 1'b1;
      end
      if (s1_raw != cur.last_level) begin
        nxt.last_level  = s1_raw;
        nxt.change_time = s1_now;
      end else if (settling) begin
        nxt.tap_seen = nxt.tap_seen;
      end else if (s1_raw && !cur.held) begin
        nxt.tap_seen      = 1'b0;
        nxt.held          = 1'b1;
        nxt.press_time    = s1_now;
        nxt.repeat_time   = s1_now;
        nxt.long_reported = 1'b0;
        stable_next       = stable_bits | bit_sel;
        latched_next      = latched_bits | bit_sel;
        ack               = 1'b1;
        if (!rel) begin
          ev = bdpe_pkg::EVENT_SHORT_PRESS;
        end
      end else if (!s1_raw && cur.held) begin
        nxt.held     = 1'b0;
        nxt.tap_seen = 1'b0;
        stable_next  = stable_bits & ~bit_sel;
        if (rel && !cur.long_reported) begin
          ev = bdpe_pkg::EVENT_SHORT_PRESS;
        end
      end else if (!s1_raw && !cur.held && cur.tap_seen) begin
        nxt.tap_seen = 1'b0;
        latched_next = latched_bits | bit_sel;
        ack          = 1'b1;
        ev           = bdpe_pkg::EVENT_SHORT_PRESS;
      end else if (s1_raw && cur.held && rel && !cur.long_reported && long_due) begin
        nxt.long_reported = 1'b1;
        ev                = bdpe_pkg::EVENT_LONG_PRESS;
      end else if (s1_raw && cur.held && !rel && repeat_due) begin
        nxt.repeat_time = s1_now;
        ev              = bdpe_pkg::EVENT_AUTO_REPEAT;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.event_res    = out_event;
  assign result.ack_pulse    = out_ack;
  assign result.stable_mask  = out_stable;
  assign result.latched_mask = out_latched;

endmodule

`default_nettype wire

[rtl/bdpe_checker.sv]
// Port-level assertions for the button debouncer, bound to its top level.
`default_nettype none

module bdpe_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_res,
  input logic       ack_pulse,
  input logic [3:0] stable_mask,
  input logic [3:0] latched_mask
);

  logic       out_accept;
  logic [3:0] last_latched;

  assign out_accept = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_latched <= '0;
    end else if (out_accept) begin
      last_latched <= latched_mask;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({event_res, ack_pulse, stable_mask, latched_mask}))
    else $error("stalled result item changed");

  a_latched_sticky: assert property (@(posedge clk) disable iff (rst)
    out_accept |-> ((latched_mask & last_latched) == last_latched) &&
      ((stable_mask & ~latched_mask) == 4'd0))
    else $error("latched mask lost a bit or misses a held button");

  a_ack_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && ack_pulse |-> event_res != bdpe_pkg::EVENT_LONG_PRESS &&
      event_res != bdpe_pkg::EVENT_AUTO_REPEAT)
    else $error("acknowledge given with a long or repeat event");

endmodule

bind button_debounce_press_events bdpe_checker u_bdpe_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .event_res    (result.event_res),
  .ack_pulse    (result.ack_pulse),
  .stable_mask  (result.stable_mask),
  .latched_mask (result.latched_mask)
);

`default_nettype wire
